// ===== hdl/gmgs_pkg.sv =====
// Package for the grid maze goal search block: field structs, cell codes,
// geometry constants. No dependencies.
`timescale 1ns / 1ps
package gmgs_pkg;
	localparam int MaxRows = 64;
	localparam int MaxCols = 64;
	localparam int Cells = MaxRows * MaxCols;
	localparam int AddrW = $clog2(Cells);
	localparam int DepthW = AddrW + 1;

	typedef enum logic [2:0] {
		CELL_EMPTY = 3'd0,
		CELL_OBST = 3'd1,
		CELL_GOAL = 3'd2,
		CELL_VISITED = 3'd3,
		CELL_FOUND = 3'd4
	} cell_t;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_READ = 1'b1;
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic [1:0] REG_ROWS = 2'd0;
	localparam logic [1:0] REG_COLS = 2'd1;
	localparam logic [1:0] REG_GOALS = 2'd2;

	localparam logic [1:0] HEAD_RIGHT = 2'd0;
	localparam logic [1:0] HEAD_DOWN = 2'd1;
	localparam logic [1:0] HEAD_LEFT = 2'd2;

	typedef struct packed {
		logic command;
		logic [1:0] cell_code;
		logic last_cell;
		logic [11:0] read_index;
	} in_item_t;

	typedef struct packed {
		logic result_kind;
		logic found_all;
		logic [12:0] goals_left;
		logic [1:0] visited_code;
		logic [1:0] path_code;
	} out_item_t;
endpackage

// ===== hdl/grid_maze_goal_search_top.sv =====
// Top level of the grid maze goal search: cell store, route flags, search
// sequencer. Depends on gmgs_pkg and gmgs_stack_ram.
//
// Usage: pulse start with an in_item while busy is low. A load item writes
// the next cell in raster order; a load with last_cell set then runs the
// depth-first search from cell (0,0) and emits one status beat. A read item
// returns the visited and path codes of one cell as one beat.
// Results appear on out_item with out_valid high for one cycle; there is no
// back-pressure, the receiver must take every beat.
// A plain load leaves the block idle, so loads can follow back to back. A read
// registers its address, reads the memory and registers the result before its
// beat shows, and the next item can be taken at the edge that takes the beat.
// The search first clears all 4096 route flags, one entry a cycle, then enters
// cell (0,0) and walks the grid: a try at a neighbour inside the grid reads the
// neighbour from the cell store, decides and writes, a try at the grid edge only
// turns the heading, and each return reads the stack and updates the route
// flag, so search time grows with the reachable area. busy drops in the cycle
// that shows the status beat.
// Reset: the cell store is undefined until loaded; registers take
// rows = cols = goal target = 1, heading right, load position 0.
// Configuration writes go through cfg_we/cfg_index/cfg_data at any edge,
// but are meant only while busy is low.
`timescale 1ns / 1ps
module grid_maze_goal_search_top (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input gmgs_pkg::in_item_t in_item,
	output logic out_valid,
	output gmgs_pkg::out_item_t out_item,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [12:0] cfg_data
);
	import gmgs_pkg::*;

	typedef enum logic [11:0] {
		ST_IDLE = 12'b000000000001,
		ST_RD_WAIT = 12'b000000000010,
		ST_RD_OUT = 12'b000000000100,
		ST_CLEAR = 12'b000000001000,
		ST_ENTER0 = 12'b000000010000,
		ST_TRY = 12'b000000100000,
		ST_TRY_WAIT = 12'b000001000000,
		ST_TRY_DEC = 12'b000010000000,
		ST_POP = 12'b000100000000,
		ST_POP_WAIT = 12'b001000000000,
		ST_POP_DEC = 12'b010000000000,
		ST_STATUS = 12'b100000000000
	} state_t;

	state_t state_q;
	logic [6:0] rows_q, cols_q;
	logic [12:0] target_q, goals_q;
	logic [DepthW-1:0] load_pos_q;
	logic [1:0] heading_q;
	logic [DepthW-1:0] depth_q;
	logic [AddrW-1:0] cur_q, nb_q, idx_q;
	logic [2:0] tries_q;
	logic [6:0] row_q, col_q;
	logic [12:0] area_q;

	// effective geometry
	logic [6:0] eff_rows, eff_cols;
	always_comb begin
		eff_rows = (rows_q == 7'd0) ? 7'd1 : (rows_q > 7'(MaxRows) ? 7'(MaxRows) : rows_q);
		eff_cols = (cols_q == 7'd0) ? 7'd1 : (cols_q > 7'(MaxCols) ? 7'(MaxCols) : cols_q);
	end
	logic [13:0] area_full;
	assign area_full = eff_rows * eff_cols;

	// cell store and route flags
	logic [2:0] cell_mem [Cells];
	logic route_mem [Cells];
	logic cell_we, route_we, route_wd;
	logic [AddrW-1:0] cell_wa, cell_ra, route_wa, route_ra;
	logic [2:0] cell_wd, cell_rd;
	logic route_rd;

	always_ff @(posedge clk) begin
		if (cell_we) cell_mem[cell_wa] <= cell_wd;
		cell_rd <= cell_mem[cell_ra];
	end
	always_ff @(posedge clk) begin
		if (route_we) route_mem[route_wa] <= route_wd;
		route_rd <= route_mem[route_ra];
	end

	// search stack: cell index and try count per level
	logic stk_we;
	logic [AddrW-1:0] stk_wa, stk_ra;
	logic [AddrW+2:0] stk_wd, stk_rd;
	gmgs_stack_ram #(.Width(AddrW + 3), .Depth(Cells)) u_stack (
		.clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
		.raddr(stk_ra), .rdata(stk_rd)
	);

	// neighbour of the current cell in the current heading
	logic nb_ok;
	logic [AddrW-1:0] nb_idx;
	always_comb begin
		nb_ok = 1'b0;
		nb_idx = cur_q;
		unique case (heading_q)
			HEAD_RIGHT: begin
				nb_ok = (col_q + 7'd1) < eff_cols;
				nb_idx = cur_q + AddrW'(1);
			end
			HEAD_DOWN: begin
				nb_ok = (row_q + 7'd1) < eff_rows;
				nb_idx = cur_q + AddrW'(eff_cols);
			end
			HEAD_LEFT: begin
				nb_ok = col_q != 7'd0;
				nb_idx = cur_q - AddrW'(1);
			end
			default: begin
				nb_ok = row_q != 7'd0;
				nb_idx = cur_q - AddrW'(eff_cols);
			end
		endcase
	end

	// neighbour coordinates
	logic [6:0] nb_row, nb_col;
	always_comb begin
		nb_row = row_q;
		nb_col = col_q;
		unique case (heading_q)
			HEAD_RIGHT: nb_col = col_q + 7'd1;
			HEAD_DOWN: nb_row = row_q + 7'd1;
			HEAD_LEFT: nb_col = col_q - 7'd1;
			default: nb_row = row_q - 7'd1;
		endcase
	end

	logic [6:0] nb_row_q, nb_col_q;
	logic [AddrW-1:0] child_q;
	logic child_route_q;
	logic [12:0] target_eff;
	assign target_eff = (target_q == 13'd0) ? 13'd1 : target_q;

	// parent index and coordinates after a return
	logic [AddrW-1:0] pidx;
	logic [6:0] div_r, div_c;

	// memory controls
	always_comb begin
		cell_we = 1'b0; cell_wa = cur_q; cell_wd = CELL_EMPTY; cell_ra = nb_idx;
		route_we = 1'b0; route_wa = cur_q; route_wd = 1'b0; route_ra = child_q;
		stk_we = 1'b0; stk_wa = cur_q; stk_wd = '0;
		stk_ra = AddrW'(depth_q - DepthW'(2));
		unique case (state_q)
			ST_IDLE: begin
				cell_ra = in_item.read_index;
				route_ra = in_item.read_index;
				if (start && in_item.command == CMD_LOAD &&
				    load_pos_q < area_full[12:0]) begin
					cell_we = 1'b1;
					cell_wa = load_pos_q[AddrW-1:0];
					cell_wd = (in_item.cell_code == 2'd3) ? CELL_OBST : 3'(in_item.cell_code);
				end
			end
			// hold the read address so the data stays valid for the reply
			ST_RD_WAIT: begin
				cell_ra = idx_q;
				route_ra = idx_q;
			end
			ST_CLEAR: begin
				route_we = 1'b1; route_wa = idx_q; route_wd = 1'b0;
				cell_ra = AddrW'(0);
			end
			ST_ENTER0: begin
				stk_we = 1'b1; stk_wa = AddrW'(0); stk_wd = {AddrW'(0), 3'd0};
				if (cell_rd == CELL_EMPTY) begin
					cell_we = 1'b1; cell_wa = AddrW'(0); cell_wd = CELL_VISITED;
				end else if (cell_rd == CELL_GOAL) begin
					cell_we = 1'b1; cell_wa = AddrW'(0); cell_wd = CELL_FOUND;
					route_we = 1'b1; route_wa = AddrW'(0); route_wd = 1'b1;
				end
			end
			ST_TRY_DEC: begin
				if (cell_rd == CELL_EMPTY) begin
					cell_we = 1'b1; cell_wa = nb_q; cell_wd = CELL_VISITED;
				end else if (cell_rd == CELL_GOAL) begin
					cell_we = 1'b1; cell_wa = nb_q; cell_wd = CELL_FOUND;
					route_we = 1'b1; route_wa = nb_q; route_wd = 1'b1;
				end
				// save the parent's try count, push the child
				if (cell_rd == CELL_EMPTY || cell_rd == CELL_GOAL) begin
					stk_we = 1'b1;
					stk_wa = AddrW'(depth_q - DepthW'(1));
					stk_wd = {cur_q, tries_q};
				end
			end
			// depth already dropped by one: keep reading the parent slot
			ST_POP_WAIT: begin
				stk_ra = AddrW'(depth_q - DepthW'(1));
			end
			ST_POP_DEC: begin
				if (child_route_q) begin
					route_we = 1'b1; route_wa = stk_rd[AddrW+2:3]; route_wd = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rows_q <= 7'd1; cols_q <= 7'd1; target_q <= 13'd1; goals_q <= 13'd1;
			load_pos_q <= '0; heading_q <= HEAD_RIGHT; depth_q <= '0;
			out_valid <= 1'b0;
		end else begin
			out_valid <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ROWS: rows_q <= cfg_data[6:0];
					REG_COLS: cols_q <= cfg_data[6:0];
					REG_GOALS: target_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (in_item.command == CMD_READ) begin
							idx_q <= in_item.read_index;
							area_q <= area_full[12:0];
							state_q <= ST_RD_WAIT;
						end else begin
							if (load_pos_q < area_full[12:0])
								load_pos_q <= load_pos_q + DepthW'(1);
							if (in_item.last_cell) begin
								idx_q <= '0;
								state_q <= ST_CLEAR;
							end
						end
					end
				end
				ST_RD_WAIT: state_q <= ST_RD_OUT;
				ST_RD_OUT: begin
					out_valid <= 1'b1;
					out_item.result_kind <= KIND_READ;
					out_item.found_all <= goals_q == 13'd0;
					out_item.goals_left <= goals_q;
					if (13'(idx_q) >= area_q) begin
						out_item.visited_code <= 2'd1; out_item.path_code <= 2'd1;
					end else begin
						unique case (cell_rd)
							CELL_EMPTY: begin
								out_item.visited_code <= 2'd0; out_item.path_code <= 2'd0;
							end
							CELL_GOAL, CELL_FOUND: begin
								out_item.visited_code <= 2'd2; out_item.path_code <= 2'd2;
							end
							CELL_VISITED: begin
								out_item.visited_code <= 2'd3;
								out_item.path_code <= route_rd ? 2'd3 : 2'd0;
							end
							default: begin
								out_item.visited_code <= 2'd1; out_item.path_code <= 2'd1;
							end
						endcase
					end
					state_q <= ST_IDLE;
				end
				ST_CLEAR: begin
					idx_q <= idx_q + AddrW'(1);
					if (idx_q == '1) begin
						heading_q <= HEAD_RIGHT;
						goals_q <= target_eff;
						state_q <= ST_ENTER0;
					end
				end
				ST_ENTER0: begin
					if (cell_rd == CELL_GOAL) goals_q <= goals_q - 13'd1;
					depth_q <= DepthW'(1);
					cur_q <= '0; tries_q <= 3'd0; row_q <= 7'd0; col_q <= 7'd0;
					state_q <= ST_TRY;
				end
				ST_TRY: begin
					if (tries_q < 3'd4 && goals_q != 13'd0) begin
						if (nb_ok) begin
							nb_q <= nb_idx; nb_row_q <= nb_row; nb_col_q <= nb_col;
							state_q <= ST_TRY_WAIT;
						end else begin
							tries_q <= tries_q + 3'd1;
							heading_q <= heading_q + 2'd1;
						end
					end else begin
						state_q <= ST_POP;
						child_q <= cur_q;
					end
				end
				ST_TRY_WAIT: state_q <= ST_TRY_DEC;
				ST_TRY_DEC: begin
					if ((cell_rd == CELL_EMPTY || cell_rd == CELL_GOAL) &&
					    depth_q < DepthW'(Cells)) begin
						if (cell_rd == CELL_GOAL && goals_q != 13'd0) goals_q <= goals_q - 13'd1;
						depth_q <= depth_q + DepthW'(1);
						cur_q <= nb_q; row_q <= nb_row_q; col_q <= nb_col_q; tries_q <= 3'd0;
					end else begin
						tries_q <= tries_q + 3'd1;
						heading_q <= heading_q + 2'd1;
					end
					state_q <= ST_TRY;
				end
				ST_POP: begin
					depth_q <= depth_q - DepthW'(1);
					if (depth_q == DepthW'(1)) begin
						state_q <= ST_STATUS;
					end else begin
						state_q <= ST_POP_WAIT;
					end
				end
				ST_POP_WAIT: state_q <= ST_POP_DEC;
				ST_POP_DEC: begin
					// stack and route reads are valid now
					cur_q <= stk_rd[AddrW+2:3];
					tries_q <= stk_rd[2:0] + 3'd1;
					heading_q <= heading_q + 2'd1;
					row_q <= div_r; col_q <= div_c;
					state_q <= ST_TRY;
				end
				ST_STATUS: begin
					out_valid <= 1'b1;
					out_item.result_kind <= KIND_STATUS;
					out_item.found_all <= goals_q == 13'd0;
					out_item.goals_left <= goals_q;
					out_item.visited_code <= 2'd0;
					out_item.path_code <= 2'd0;
					load_pos_q <= '0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// route flag of the returning child, captured in the cycle after its read
	always_ff @(posedge clk) begin
		if (state_q == ST_POP_WAIT) child_route_q <= route_rd;
	end

	// parent coordinates: the parent is one step away from the child, so the
	// index difference tells the direction; with one column the steps of one
	// index are vertical
	assign pidx = stk_rd[AddrW+2:3];
	always_comb begin
		div_r = row_q; div_c = col_q;
		if (pidx == child_q + AddrW'(1) && (col_q + 7'd1) < eff_cols) div_c = col_q + 7'd1;
		else if (pidx == child_q - AddrW'(1) && col_q != 7'd0) div_c = col_q - 7'd1;
		else if (pidx == child_q + AddrW'(eff_cols)) div_r = row_q + 7'd1;
		else div_r = row_q - 7'd1;
	end

	assign busy = state_q != ST_IDLE;

	// checks
	a_status_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == ST_IDLE) else $error("beat outside idle");
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DepthW'(Cells)) else $error("stack overflow");
	a_goals_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TRY) |-> goals_q <= target_eff) else $error("goal count");
endmodule

// ===== hdl/gmgs_stack_ram.sv =====
// Generic one-port-write, one-port-read synchronous RAM with registered read.
// Used for the search stack. No dependencies.
`timescale 1ns / 1ps
module gmgs_stack_ram #(
	parameter int Width = 15,
	parameter int Depth = 4096
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	// write port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule
